### src/shortest_queue_dispatch_sim_top_assert.svh
// ----------------------------------------------------------------------------
// shortest_queue_dispatch_sim_top_assert.svh
// Assertion macros used by the dispatcher datapath. They expect signals
// named clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_QUEUE_DISPATCH_SIM_TOP_ASSERT_SVH
`define SHORTEST_QUEUE_DISPATCH_SIM_TOP_ASSERT_SVH

// same-cycle implication, idle during reset
`define SQD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define SQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sqd_pkg.sv
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared constants, codes and controller/datapath interface types for the
// shortest-queue dispatcher.
// ----------------------------------------------------------------------------
package sqd_pkg;

  // default sizing
  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;

  // results caused by one item at most
  localparam int MAX_RESULTS = 64;
  localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

  // field widths
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int ACT_W   = 3;
  localparam int QIDX_W  = 2;
  localparam int ENTRY_W = ID_W + TIME_W;

  // active queue register reset value
  localparam logic [ACT_W-1:0] ACTIVE_RESET = 3'd4;

  // item and result codes
  localparam logic MODE_DRAIN  = 1'b1;
  localparam logic KIND_DEPART = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic dscan;
    logic pop;
    logic refill;
    logic scan_init;
    logic tscan;
    logic place;
    logic flush;
  } sqd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic dscan_last;
    logic tscan_last;
    logic found;
    logic n_full;
    logic drain;
  } sqd_status_t;

endpackage

### src/sqd_ctrl.sv
// ----------------------------------------------------------------------------
// sqd_ctrl
// Sequencer for the dispatcher: departure scans, pops with head refill,
// shortest-queue search, placement and final result flush.
// ----------------------------------------------------------------------------
module sqd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sqd_pkg::sqd_status_t status,
  output sqd_pkg::sqd_cmd_t    cmd,
  output logic                busy
);
  import sqd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSCAN,
    ST_DECIDE,
    ST_REFILL,
    ST_TSCAN,
    ST_PLACE,
    ST_FLUSH
  } state_t;

  state_t state, state_next;

  // next state and command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DSCAN;
        end
      end
      ST_DSCAN: begin
        cmd.dscan = 1'b1;
        if (status.dscan_last) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.found && !status.n_full) begin
          cmd.pop    = 1'b1;
          state_next = ST_REFILL;
        end else if (status.drain) begin
          state_next = ST_FLUSH;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = ST_TSCAN;
        end
      end
      ST_REFILL: begin
        cmd.refill = 1'b1;
        state_next = ST_DSCAN;
      end
      ST_TSCAN: begin
        cmd.tscan = 1'b1;
        if (status.tscan_last) state_next = ST_PLACE;
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

### src/sqd_datapath.sv
// ----------------------------------------------------------------------------
// sqd_datapath
// Queue bookkeeping, entry store, cached queue heads, scan registers and the
// result holding register that lets the last result of an item be marked.
// ----------------------------------------------------------------------------
`include "shortest_queue_dispatch_sim_top_assert.svh"

module sqd_datapath #(
  parameter int NUM_QUEUES  = sqd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sqd_pkg::sqd_cmd_t            cmd,
  output sqd_pkg::sqd_status_t         status,
  input  logic                        mode,
  input  logic [sqd_pkg::ID_W-1:0]    customer_id,
  input  logic [sqd_pkg::TIME_W-1:0]  arrival_time,
  input  logic [sqd_pkg::TIME_W-1:0]  service_time,
  input  logic                        cfg_we,
  input  logic [sqd_pkg::ACT_W-1:0]   cfg_data,
  output logic                        strobe,
  output logic                        kind,
  output logic [sqd_pkg::ID_W-1:0]    out_id,
  output logic [sqd_pkg::TIME_W-1:0]  finish_time,
  output logic [sqd_pkg::QIDX_W-1:0]  queue_index,
  output logic                        last
);
  import sqd_pkg::*;

  localparam int QIW         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int SW          = HW + 1;
  localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CMPW        = QIW + ACT_W + 1;

  localparam logic [QIW-1:0] LAST_Q   = QIW'(NUM_QUEUES - 1);
  localparam logic [HW-1:0]  HEAD_MAX = HW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0]  DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0]  DEPTH_S  = SW'(QUEUE_DEPTH);

  // configuration and latched item
  logic [ACT_W-1:0]  active_queues;
  logic              mode_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] arr_r;
  logic [TIME_W-1:0] svc_r;
  logic [TIME_W-1:0] limit_r;

  // per-queue state
  logic [HW-1:0]     head [NUM_QUEUES];
  logic [CW-1:0]     count [NUM_QUEUES];
  logic [TIME_W-1:0] tail [NUM_QUEUES];
  logic [TIME_W-1:0] hf [NUM_QUEUES];
  logic [ID_W-1:0]   hid [NUM_QUEUES];

  // scan registers
  logic [QIW-1:0]    idx;
  logic [QIW-1:0]    sel;
  logic              found;
  logic [TIME_W-1:0] best_t;
  logic [ID_W-1:0]   best_id;
  logic [HW-1:0]     best_head;
  logic [CW-1:0]     best_count;
  logic [TIME_W-1:0] best_tail;
  logic [NCNT_W-1:0] n;

  // held result
  logic              pend_valid;
  logic              pend_kind;
  logic [ID_W-1:0]   pend_id;
  logic [TIME_W-1:0] pend_time;
  logic [QIW-1:0]    pend_q;

  // entry store
  logic [ENTRY_W-1:0] mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rdata;
  logic [AW-1:0]      base;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               mem_we;

  // combinational terms
  logic [CW-1:0]     cur_count;
  logic [HW-1:0]     cur_head;
  logic [TIME_W-1:0] cur_hf;
  logic [ID_W-1:0]   cur_hid;
  logic [TIME_W-1:0] cur_tail;
  logic              dscan_hit;
  logic              tscan_hit;
  logic              idx_last;
  logic              tscan_last;
  logic [HW-1:0]     head_next;
  logic [SW-1:0]     slot_sum;
  logic [SW-1:0]     slot;
  logic              q_full;
  logic [TIME_W-1:0] start_t;
  logic [TIME_W:0]   fin_sum;
  logic [TIME_W-1:0] fin;
  logic              n_full;
  logic              emit;
  logic              new_kind;
  logic [ID_W-1:0]   new_id;
  logic [TIME_W-1:0] new_time;

  // reads of the queue selected by the scan index
  assign cur_count = count[idx];
  assign cur_head  = head[idx];
  assign cur_hf    = hf[idx];
  assign cur_hid   = hid[idx];
  assign cur_tail  = tail[idx];

  // earliest eligible head, strict compare keeps lower index on ties
  assign dscan_hit = (cur_count != '0) && (cur_hf <= limit_r) && (!found || cur_hf < best_t);
  // fewest entries, strict compare keeps lower index on ties
  assign tscan_hit = (idx == '0) || (cur_count < best_count);

  assign idx_last   = (idx == LAST_Q);
  assign tscan_last = idx_last || (CMPW'(idx) + CMPW'(1) >= CMPW'(active_queues));

  // store addressing
  assign head_next = (best_head == HEAD_MAX) ? '0 : best_head + HW'(1);
  assign base      = AW'(sel) * AW'(QUEUE_DEPTH);
  assign raddr     = base + AW'(head_next);
  assign slot_sum  = SW'(best_head) + SW'(best_count);
  assign slot      = (slot_sum >= DEPTH_S) ? slot_sum - DEPTH_S : slot_sum;
  assign waddr     = base + AW'(slot);

  // finish time of the arrival, saturating
  assign q_full  = (best_count >= DEPTH_C);
  assign start_t = (best_count != '0 && best_tail > arr_r) ? best_tail : arr_r;
  assign fin_sum = {1'b0, start_t} + {1'b0, svc_r};
  assign fin     = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
  assign mem_we  = cmd.place && !q_full;

  // new result creation
  assign n_full   = (n == NCNT_W'(MAX_RESULTS));
  assign emit     = cmd.pop || (cmd.place && q_full && !n_full);
  assign new_kind = cmd.pop ? KIND_DEPART : KIND_REJECT;
  assign new_id   = cmd.pop ? best_id : id_r;
  assign new_time = cmd.pop ? best_t : arr_r;

  assign status.dscan_last = idx_last;
  assign status.tscan_last = tscan_last;
  assign status.found      = found;
  assign status.n_full     = n_full;
  assign status.drain      = (mode_r == MODE_DRAIN);

  // control state and queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      active_queues <= ACTIVE_RESET;
      idx           <= '0;
      found         <= 1'b0;
      n             <= '0;
      pend_valid    <= 1'b0;
      strobe        <= 1'b0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head[q]  <= '0;
        count[q] <= '0;
        tail[q]  <= '0;
      end
    end else begin
      strobe <= 1'b0;
      if (cfg_we) active_queues <= cfg_data;
      if (cmd.load) begin
        idx   <= '0;
        found <= 1'b0;
        n     <= '0;
      end
      if (cmd.scan_init) idx <= '0;
      if (cmd.dscan) begin
        if (dscan_hit) found <= 1'b1;
        if (!idx_last) idx <= idx + QIW'(1);
      end
      if (cmd.tscan && !tscan_last) idx <= idx + QIW'(1);
      if (cmd.pop) begin
        head[sel]  <= head_next;
        count[sel] <= best_count - CW'(1);
        found      <= 1'b0;
        idx        <= '0;
      end
      if (mem_we) begin
        count[sel] <= best_count + CW'(1);
        tail[sel]  <= fin;
      end
      if (emit) begin
        if (pend_valid) strobe <= 1'b1;
        pend_valid <= 1'b1;
        n          <= n + NCNT_W'(1);
      end
      if (cmd.flush && pend_valid) begin
        strobe     <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mode;
      id_r    <= customer_id;
      arr_r   <= arrival_time;
      svc_r   <= service_time;
      limit_r <= (mode == MODE_DRAIN) ? '1 : arrival_time;
    end
    if (cmd.dscan && dscan_hit) begin
      sel        <= idx;
      best_t     <= cur_hf;
      best_id    <= cur_hid;
      best_head  <= cur_head;
      best_count <= cur_count;
    end
    if (cmd.tscan && tscan_hit) begin
      sel        <= idx;
      best_head  <= cur_head;
      best_count <= cur_count;
      best_tail  <= cur_tail;
    end
    // older held result goes out, new one takes its place
    if (emit) begin
      kind        <= pend_kind;
      out_id      <= pend_id;
      finish_time <= pend_time;
      queue_index <= QIDX_W'(pend_q);
      last        <= 1'b0;
      pend_kind   <= new_kind;
      pend_id     <= new_id;
      pend_time   <= new_time;
      pend_q      <= sel;
    end
    if (cmd.flush) begin
      kind        <= pend_kind;
      out_id      <= pend_id;
      finish_time <= pend_time;
      queue_index <= QIDX_W'(pend_q);
      last        <= 1'b1;
    end
  end

  // cached queue heads
  always_ff @(posedge clk) begin
    if (cmd.refill) begin
      hf[sel]  <= rdata[TIME_W-1:0];
      hid[sel] <= rdata[ENTRY_W-1:TIME_W];
    end
    if (mem_we && best_count == '0) begin
      hf[sel]  <= fin;
      hid[sel] <= id_r;
    end
  end

  // entry store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= {id_r, fin};
    rdata <= mem[raddr];
  end

  `SQD_ASSERT_IMP(a_pop_nonempty, cmd.pop, best_count != '0, "pop from an empty queue")
  `SQD_ASSERT_IMP(a_pop_in_budget, cmd.pop, !n_full, "departure beyond the result limit")
  `SQD_ASSERT_IMP(a_n_bound, emit, n < NCNT_W'(MAX_RESULTS), "result count overflow")
  `SQD_ASSERT_NEXT(a_flush_clears, cmd.flush, !pend_valid, "held result left after flush")
  `SQD_ASSERT_IMP(a_last_alone, strobe && last, !pend_valid, "result held behind a last one")

endmodule

### src/shortest_queue_dispatch_sim_top.sv
// ----------------------------------------------------------------------------
// shortest_queue_dispatch_sim_top
// Join-shortest-queue dispatcher for several FIFO servers, with departure
// events released in finish-time order.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; results come out one
// per strobe cycle and cannot be stalled, so the receiver must take every
// strobe. The final result of an item carries last; an item that causes no
// result gives no strobe. Each departure costs one head scan of one queue per
// cycle plus a pop and a head refill from the entry store; an arrival then
// takes a shortest-queue search over the first A queues, a placement and a
// flush, where A is active_queues held to the range 1 to NUM_QUEUES (a drain
// takes only the flush). No clearing pass is needed after reset.
// active_queues may be written through cfg_valid/cfg_ready while busy is low.
// ----------------------------------------------------------------------------
module shortest_queue_dispatch_sim_top #(
  parameter int NUM_QUEUES  = sqd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [sqd_pkg::ID_W-1:0]    customer_id,
  input  logic [sqd_pkg::TIME_W-1:0]  arrival_time,
  input  logic [sqd_pkg::TIME_W-1:0]  service_time,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sqd_pkg::ACT_W-1:0]   cfg_data,
  output logic                        strobe,
  output logic                        kind,
  output logic [sqd_pkg::ID_W-1:0]    out_id,
  output logic [sqd_pkg::TIME_W-1:0]  finish_time,
  output logic [sqd_pkg::QIDX_W-1:0]  queue_index,
  output logic                        last
);
  import sqd_pkg::*;

  sqd_cmd_t    cmd;
  sqd_status_t status;

  // register writes only between items
  assign cfg_ready = !busy;

  sqd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sqd_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .mode         (mode),
    .customer_id  (customer_id),
    .arrival_time (arrival_time),
    .service_time (service_time),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .kind         (kind),
    .out_id       (out_id),
    .finish_time  (finish_time),
    .queue_index  (queue_index),
    .last         (last)
  );

endmodule
